/* rtl/ray_segment_clip_macros.svh */
// ---------------------------------------------------------------------------
// ray_segment_clip assertion macros
// Shared property shapes for the ray clipping block.
// ---------------------------------------------------------------------------
`ifndef RAY_SEGMENT_CLIP_MACROS_SVH
`define RAY_SEGMENT_CLIP_MACROS_SVH

// same-cycle implication
`define RSC_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rsc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsc_pkg
// Types, widths and helpers shared by the ray clipping block.
// ---------------------------------------------------------------------------
package rsc_pkg;

   localparam int COORD_W = 24;
   localparam int DIFF_W  = 25;
   localparam int MUL_W   = 26;
   localparam int PROD_W  = 52;
   localparam int S_BITS  = 16;
   localparam int Q_W     = S_BITS + 1;
   localparam int CNT_W   = 9;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic        [PROD_W-1:0]  mag_type;
   typedef logic        [Q_W-1:0]     quot_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // num/den inside the closed unit range, den nonzero
   function automatic logic in_unit(input prod_type num, input prod_type den);
      if (den > 0) begin
         return (num >= 0) && (num <= den);
      end
      return (num <= 0) && (num >= den);
   endfunction

endpackage

/* rtl/rsc_frac_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rsc_frac_div
// Restoring divider: floor(num * 2^16 / den) for num <= den, one bit a cycle.
// ---------------------------------------------------------------------------
module rsc_frac_div
   import rsc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  mag_type        num,
   input  mag_type        den,
   output div_status_type status,
   output quot_type       quot
);

   localparam logic [4:0] LAST_STEP = 5'(S_BITS);

   logic              busy_ff, done_ff;
   logic [4:0]        step_ff;
   logic [PROD_W:0]   rem_ff, rem_in, shifted;
   mag_type           den_ff;
   quot_type          quot_ff;
   logic              ge;

   // first step compares without shifting (integer bit of the quotient)
   always_comb begin
      shifted = (step_ff == '0) ? rem_ff : {rem_ff[PROD_W-1:0], 1'b0};
      ge      = shifted >= {1'b0, den_ff};
      rem_in  = ge ? (shifted - {1'b0, den_ff}) : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= {1'b0, num};
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[Q_W-2:0], ge};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quot_ff;

endmodule

/* rtl/ray_segment_clip.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ray_segment_clip
// Clips a 2D ray against a table of wall segments, one shared multiplier.
// ---------------------------------------------------------------------------
// A request with tuser = 0 stores one wall (start, end) at wall_index in a
// MAX_WALLS-entry table; entries at or beyond MAX_WALLS drop.
// A request with tuser = 1 casts a ray from start to end over walls 0 to
// wall_count-1 (capped at MAX_WALLS); every hit pulls the end point in, and
// the final end point comes back as one response. Each tested wall costs a
// table read and six products through the single 26x26 multiplier, and
// each hit a bit-serial divide and the scale X, scale Y and finish steps.
// No clearing pass: walls must be written before rays read them.
// The request side stays busy while a ray is walked; a finished response
// waits in the output register while the next request is taken.
// ---------------------------------------------------------------------------
`include "ray_segment_clip_macros.svh"

module ray_segment_clip
   import rsc_pkg::*;
#(
   parameter int MAX_WALLS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // wall_index[7:0], start_x[31:8], start_y[55:32], end_x[79:56], end_y[103:80]
   input  logic [103:0]       req_tdata,
   // func[0]: 0 write wall, 1 cast ray
   input  logic [0:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // hit_x[23:0], hit_y[47:24]
   output logic [47:0]        rsp_tdata,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CNT_W-1:0]   csr_data
);

   localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int CW = $clog2(MAX_WALLS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_LOAD, S_MAC, S_TEST, S_DIVIDE,
      S_SCALE_X, S_SCALE_Y, S_SCALE_FIN, S_ADVANCE, S_FINISH
   } state_type;

   state_type        state_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] wall_count_ff;
   logic [CW-1:0]    wall_idx_ff, limit_ff, limit_in, wall_idx_in;
   logic [2:0]       mac_step_ff;

   coord_type        ax_ff, ay_ff, bx_ff, by_ff, hit_x_ff, hit_y_ff;
   diff_type         l1x_ff, l1y_ff, l2x_ff, l2y_ff, dx_ff, dy_ff;
   prod_type         prod_ff, acc_ff, dr_ff, nr_ff, ns_ff;
   logic [95:0]      wall_mem [MAX_WALLS];
   logic [95:0]      wall_rd_ff;

   logic             req_accept, wall_wr;
   logic [AW-1:0]    wall_wr_addr;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic             parallel, hit;
   div_status_type   div_status;
   quot_type         quot;
   mag_type          div_num, div_den;
   diff_type         scale_mag, scale_val, scale_sum;
   logic             scale_neg;
   coord_type        scale_base, wsx, wsy, wex, wey;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {hit_y_ff, hit_x_ff};

   // wall table: one write port, one registered read port
   assign wall_wr      = req_accept && !req_tuser[0]
                         && (32'(req_tdata[7:0]) < 32'(MAX_WALLS));
   assign wall_wr_addr = AW'(req_tdata[7:0]);

   always_ff @(posedge clock) begin
      if (wall_wr) begin
         wall_mem[wall_wr_addr] <= req_tdata[103:8];
      end
      wall_rd_ff <= wall_mem[wall_idx_ff[AW-1:0]];
   end

   assign wsx = $signed(wall_rd_ff[23:0]);
   assign wsy = $signed(wall_rd_ff[47:24]);
   assign wex = $signed(wall_rd_ff[71:48]);
   assign wey = $signed(wall_rd_ff[95:72]);

   // tested walls: wall_count capped at the table size
   assign limit_in    = (32'(wall_count_ff) > 32'(MAX_WALLS)) ? CW'(MAX_WALLS)
                                                              : CW'(wall_count_ff);
   assign wall_idx_in = wall_idx_ff + 1'b1;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_MAC: begin
            unique case (mac_step_ff)
               3'd0:    begin mul_a = MUL_W'(l2x_ff); mul_b = MUL_W'(l1y_ff); end
               3'd1:    begin mul_a = MUL_W'(l2y_ff); mul_b = MUL_W'(l1x_ff); end
               3'd2:    begin mul_a = MUL_W'(l1x_ff); mul_b = MUL_W'(dy_ff);  end
               3'd3:    begin mul_a = MUL_W'(l1y_ff); mul_b = MUL_W'(dx_ff);  end
               3'd4:    begin mul_a = MUL_W'(l2y_ff); mul_b = MUL_W'(dx_ff);  end
               3'd5:    begin mul_a = MUL_W'(l2x_ff); mul_b = MUL_W'(dy_ff);  end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         S_SCALE_X: begin
            mul_a = l1x_ff[DIFF_W-1] ? -MUL_W'(l1x_ff) : MUL_W'(l1x_ff);
            mul_b = MUL_W'(quot);
         end
         S_SCALE_Y: begin
            mul_a = l1y_ff[DIFF_W-1] ? -MUL_W'(l1y_ff) : MUL_W'(l1y_ff);
            mul_b = MUL_W'(quot);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // hit test: ds is -dr, so one determinant covers both parameters
   assign parallel = ((l2x_ff == l1x_ff) && (l2y_ff == l1y_ff))
                     || ((l2x_ff == -l1x_ff) && (l2y_ff == -l1y_ff));
   assign hit      = !parallel && (dr_ff != '0)
                     && in_unit(nr_ff, dr_ff) && in_unit(ns_ff, -dr_ff);
   assign div_num  = ns_ff[PROD_W-1] ? mag_type'(-ns_ff) : mag_type'(ns_ff);
   assign div_den  = dr_ff[PROD_W-1] ? mag_type'(-dr_ff) : mag_type'(dr_ff);

   rsc_frac_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  ((state_ff == S_TEST) && hit),
      .num    (div_num),
      .den    (div_den),
      .status (div_status),
      .quot   (quot)
   );

   // scaled step toward the hit: drop 16 fraction bits, restore the sign
   assign scale_neg  = (state_ff == S_SCALE_Y) ? l1x_ff[DIFF_W-1] : l1y_ff[DIFF_W-1];
   assign scale_base = (state_ff == S_SCALE_Y) ? ax_ff : ay_ff;
   assign scale_mag  = $signed(prod_ff[S_BITS +: DIFF_W]);
   assign scale_val  = scale_neg ? -scale_mag : scale_mag;
   assign scale_sum  = DIFF_W'(scale_base) + scale_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         wall_count_ff <= '0;
         wall_idx_ff   <= '0;
         limit_ff      <= '0;
         mac_step_ff   <= '0;
      end else begin
         if (csr_valid) begin
            wall_count_ff <= csr_data;
         end
         // finish reloads the output register itself
         if (rsp_valid_ff && rsp_tready && (state_ff != S_FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               // latch the ray; wall writes finish in the table write
               if (req_accept && req_tuser[0]) begin
                  ax_ff       <= $signed(req_tdata[31:8]);
                  ay_ff       <= $signed(req_tdata[55:32]);
                  bx_ff       <= $signed(req_tdata[79:56]);
                  by_ff       <= $signed(req_tdata[103:80]);
                  wall_idx_ff <= '0;
                  limit_ff    <= limit_in;
                  state_ff    <= (limit_in == '0) ? S_FINISH : S_FETCH;
               end
            end
            S_FETCH: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               l1x_ff      <= DIFF_W'(bx_ff) - DIFF_W'(ax_ff);
               l1y_ff      <= DIFF_W'(by_ff) - DIFF_W'(ay_ff);
               l2x_ff      <= DIFF_W'(wex) - DIFF_W'(wsx);
               l2y_ff      <= DIFF_W'(wey) - DIFF_W'(wsy);
               dx_ff       <= DIFF_W'(wsx) - DIFF_W'(ax_ff);
               dy_ff       <= DIFF_W'(wsy) - DIFF_W'(ay_ff);
               mac_step_ff <= '0;
               state_ff    <= S_MAC;
            end
            S_MAC: begin
               // product k-1 sits in prod_ff while step k issues
               mac_step_ff <= mac_step_ff + 3'd1;
               unique case (mac_step_ff)
                  3'd1, 3'd3, 3'd5: acc_ff <= prod_ff;
                  3'd2: dr_ff <= acc_ff - prod_ff;
                  3'd4: nr_ff <= acc_ff - prod_ff;
                  3'd6: begin
                     ns_ff    <= acc_ff - prod_ff;
                     state_ff <= S_TEST;
                  end
                  default: begin
                  end
               endcase
            end
            S_TEST: begin
               state_ff <= hit ? S_DIVIDE : S_ADVANCE;
            end
            S_DIVIDE: begin
               if (div_status.done) begin
                  state_ff <= S_SCALE_X;
               end
            end
            S_SCALE_X: begin
               state_ff <= S_SCALE_Y;
            end
            S_SCALE_Y: begin
               bx_ff    <= COORD_W'(scale_sum);
               state_ff <= S_SCALE_FIN;
            end
            S_SCALE_FIN: begin
               by_ff    <= COORD_W'(scale_sum);
               state_ff <= S_ADVANCE;
            end
            S_ADVANCE: begin
               wall_idx_ff <= wall_idx_in;
               state_ff    <= (wall_idx_in == limit_ff) ? S_FINISH : S_FETCH;
            end
            S_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  hit_x_ff     <= bx_ff;
                  hit_y_ff     <= by_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `RSC_ASSERT_IMPL(a_div_done_in_divide, clock, reset, div_status.done, state_ff == S_DIVIDE, "divider finished outside divide state")
   `RSC_ASSERT_NEXT(a_ray_leaves_idle, clock, reset, req_accept && req_tuser[0], state_ff != S_IDLE, "ray request did not start a walk")
   `RSC_ASSERT_IMPL(a_fetch_in_range, clock, reset, state_ff == S_FETCH, wall_idx_ff < limit_ff, "wall index beyond tested count")
   `RSC_ASSERT_NEXT(a_rsp_only_from_finish, clock, reset, (state_ff != S_FINISH) && !rsp_valid_ff, !rsp_valid_ff, "response raised outside finish")

endmodule
